### rtl/mcsd_pkg.sv
// Shared types, constants and helpers for the movie chunk stream decoder.
// No dependencies; every other file in rtl/ imports this package.
package mcsd_pkg;

  // Address width of pixel and ring addresses (wraps at 2^ADDR_BITS)
  localparam int ADDR_BITS     = 24;
  localparam int PAL_ENTRIES   = 256;
  localparam int PAL_IDX_BITS  = $clog2(PAL_ENTRIES);
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_BASE     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_STRIDE     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RING_SIZE      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SERVE_SIZE     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OVERSCAN_COLOR = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PALETTE_SHIFT  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [15:0] ROW_STRIDE_RST  = 16'd200;
  localparam logic [15:0] RING_SIZE_RST   = 16'd22050;
  localparam logic [15:0] SERVE_SIZE_RST  = 16'd2205;
  localparam logic [1:0]  PAL_SHIFT_RST   = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_PIXEL   = 3'd0;
  localparam logic [2:0] KIND_PALETTE = 3'd1;
  localparam logic [2:0] KIND_AUDIO   = 3'd2;
  localparam logic [2:0] KIND_SERVED  = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  // Chunk kinds after the type byte is decremented
  localparam logic [1:0] CHUNK_PALETTE = 2'd0;
  localparam logic [1:0] CHUNK_SOUND   = 2'd1;
  localparam logic [1:0] CHUNK_IMAGE   = 2'd2;
  localparam logic [1:0] CHUNK_DONE    = 2'd3;

  typedef struct packed {
    logic [ADDR_BITS-1:0] frame_base;
    logic [15:0]          row_stride;
    logic [15:0]          ring_size;
    logic [15:0]          serve_size;
    logic [7:0]           overscan_color;
    logic [1:0]           palette_shift;
  } cfg_t;

  // One result descriptor; quad expands into four beats at address+0..3
  typedef struct packed {
    logic [2:0]           kind;
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           value;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 quad;
  } res_t;

  // Palette component scaling, truncated to 8 bits
  function automatic logic [7:0] shade(input logic [7:0] c, input logic [1:0] sh);
    logic [7:0] r;
    r = c << sh;
    return r;
  endfunction

endpackage

### rtl/mcsd_cfg_regs.sv
// Configuration register file of the movie chunk stream decoder.
// Depends on mcsd_pkg.
module mcsd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [mcsd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mcsd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output mcsd_pkg::cfg_t                      cfg
);
  import mcsd_pkg::*;

  // Write-only registers, one per index; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_base     <= '0;
      cfg.row_stride     <= ROW_STRIDE_RST;
      cfg.ring_size      <= RING_SIZE_RST;
      cfg.serve_size     <= SERVE_SIZE_RST;
      cfg.overscan_color <= '0;
      cfg.palette_shift  <= PAL_SHIFT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_FRAME_BASE:     cfg.frame_base     <= cfg_data[ADDR_BITS-1:0];
        CFG_ROW_STRIDE:     cfg.row_stride     <= cfg_data[15:0];
        CFG_RING_SIZE:      cfg.ring_size      <= cfg_data[15:0];
        CFG_SERVE_SIZE:     cfg.serve_size     <= cfg_data[15:0];
        CFG_OVERSCAN_COLOR: cfg.overscan_color <= cfg_data[7:0];
        CFG_PALETTE_SHIFT:  cfg.palette_shift  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/mcsd_parser.sv
// Chunk parser: stream state machine, ring pointers and result descriptor.
// Depends on mcsd_pkg.
module mcsd_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           action,
  input  logic [7:0]     data_byte,
  input  mcsd_pkg::cfg_t cfg,
  output logic           res_valid,
  output mcsd_pkg::res_t res
);
  import mcsd_pkg::*;

  typedef enum logic [10:0] {
    PH_TYPE     = 11'b000_0000_0001,
    PH_SIZE     = 11'b000_0000_0010,
    PH_IGNSIZE  = 11'b000_0000_0100,
    PH_PAL      = 11'b000_0000_1000,
    PH_PALTRAIL = 11'b000_0001_0000,
    PH_SOUND    = 11'b000_0010_0000,
    PH_IMG_Y0   = 11'b000_0100_0000,
    PH_IMG_Y1   = 11'b000_1000_0000,
    PH_IMG_X    = 11'b001_0000_0000,
    PH_IMG_N    = 11'b010_0000_0000,
    PH_IMG_PIX  = 11'b100_0000_0000
  } phase_t;

  phase_t                  phase, phase_next;
  logic [1:0]              chunk_kind, chunk_kind_next;
  logic [31:0]             size_left, size_left_next;
  logic [1:0]              size_cnt, size_cnt_next;
  logic [1:0]              pal_lane, pal_lane_next;
  logic [PAL_IDX_BITS-1:0] pal_entry, pal_entry_next;
  logic [15:0]             held_color, held_color_next;
  logic [15:0]             row_offset, row_offset_next;
  logic [ADDR_BITS-1:0]    pixel_pointer, pixel_pointer_next;
  logic [7:0]              run_left, run_left_next;
  logic                    sound_dropping, sound_dropping_next;
  logic [15:0]             ring_write_pos, ring_write_pos_next;
  logic [15:0]             ring_read_pos, ring_read_pos_next;
  logic [31:0]             bytes_received, bytes_received_next;
  logic [31:0]             bytes_consumed, bytes_consumed_next;

  // Shared arithmetic
  logic [7:0]  type_dec;
  logic [31:0] size_or, size_dec1, size_dec2, fill_level, row_prod;
  logic [16:0] wr_inc, serve_sum;
  logic [7:0]  run_dec;

  assign type_dec   = data_byte - 8'd1;
  assign size_or    = size_left | (32'(data_byte) << {size_cnt, 3'b000});
  assign size_dec1  = (size_left > 32'd1) ? size_left - 32'd1 : '0;
  assign size_dec2  = (size_left > 32'd2) ? size_left - 32'd2 : '0;
  assign fill_level = bytes_received - bytes_consumed;
  assign wr_inc     = {1'b0, ring_write_pos} + 17'd1;
  assign serve_sum  = {1'b0, ring_read_pos} + {1'b0, cfg.serve_size};
  assign row_prod   = {data_byte, row_offset[7:0]} * cfg.row_stride;
  assign run_dec    = run_left - 8'd1;

  // Next state and result descriptor for the accepted beat
  always_comb begin
    phase_next          = phase;
    chunk_kind_next     = chunk_kind;
    size_left_next      = size_left;
    size_cnt_next       = size_cnt;
    pal_lane_next       = pal_lane;
    pal_entry_next      = pal_entry;
    held_color_next     = held_color;
    row_offset_next     = row_offset;
    pixel_pointer_next  = pixel_pointer;
    run_left_next       = run_left;
    sound_dropping_next = sound_dropping;
    ring_write_pos_next = ring_write_pos;
    ring_read_pos_next  = ring_read_pos;
    bytes_received_next = bytes_received;
    bytes_consumed_next = bytes_consumed;
    res_valid           = 1'b0;
    res                 = '0;

    if (accept) begin
      if (action) begin
        // Serve request: report block start, advance tail
        res_valid     = 1'b1;
        res.kind      = KIND_SERVED;
        res.address   = ADDR_BITS'(ring_read_pos);
        if (serve_sum >= {1'b0, cfg.ring_size})
          ring_read_pos_next = serve_sum[15:0] - cfg.ring_size;
        else
          ring_read_pos_next = serve_sum[15:0];
        bytes_consumed_next = bytes_consumed + 32'(cfg.serve_size);
      end else begin
        case (phase)
          PH_TYPE: begin
            size_cnt_next  = '0;
            size_left_next = '0;
            if (type_dec > 8'd3) begin
              phase_next = PH_IGNSIZE;
            end else begin
              chunk_kind_next = type_dec[1:0];
              phase_next      = PH_SIZE;
            end
          end
          PH_SIZE, PH_IGNSIZE: begin
            size_left_next = size_or;
            size_cnt_next  = size_cnt + 2'd1;
            if (size_cnt == 2'd3) begin
              phase_next = PH_TYPE;
              if (phase == PH_SIZE) begin
                case (chunk_kind)
                  CHUNK_PALETTE: begin
                    pal_lane_next   = '0;
                    pal_entry_next  = '0;
                    held_color_next = '0;
                    phase_next      = PH_PAL;
                  end
                  CHUNK_SOUND: begin
                    if (size_or != '0) begin
                      sound_dropping_next = fill_level >= 32'(cfg.ring_size);
                      phase_next          = PH_SOUND;
                    end
                  end
                  CHUNK_IMAGE: begin
                    if (size_or != '0) begin
                      row_offset_next = '0;
                      phase_next      = PH_IMG_Y0;
                    end
                  end
                  default: begin
                    res_valid = 1'b1;
                    res.kind  = KIND_DONE;
                  end
                endcase
              end
            end
          end
          PH_PAL: begin
            case (pal_lane)
              2'd0: begin
                held_color_next = {8'd0, data_byte};
                pal_lane_next   = 2'd1;
              end
              2'd1: begin
                held_color_next = {data_byte, held_color[7:0]};
                pal_lane_next   = 2'd2;
              end
              default: begin
                res_valid      = 1'b1;
                res.kind       = KIND_PALETTE;
                res.address    = ADDR_BITS'(pal_entry);
                res.red        = shade(held_color[7:0], cfg.palette_shift);
                res.green      = shade(held_color[15:8], cfg.palette_shift);
                res.blue       = shade(data_byte, cfg.palette_shift);
                pal_lane_next  = 2'd0;
                pal_entry_next = pal_entry + 1'b1;
                if (pal_entry == PAL_IDX_BITS'(PAL_ENTRIES - 1))
                  phase_next = PH_PALTRAIL;
              end
            endcase
          end
          PH_PALTRAIL: begin
            // Four overscan writes at frame base
            res_valid   = 1'b1;
            res.kind    = KIND_PIXEL;
            res.address = cfg.frame_base;
            res.value   = cfg.overscan_color;
            res.quad    = 1'b1;
            phase_next  = PH_TYPE;
          end
          PH_SOUND: begin
            if (!sound_dropping) begin
              res_valid   = 1'b1;
              res.kind    = KIND_AUDIO;
              res.address = ADDR_BITS'(ring_write_pos);
              res.value   = data_byte;
              ring_write_pos_next = (wr_inc >= {1'b0, cfg.ring_size}) ? '0 : wr_inc[15:0];
              bytes_received_next = bytes_received + 32'd1;
            end
            size_left_next = size_left - 32'd1;
            if (size_left == 32'd1)
              phase_next = PH_TYPE;
          end
          PH_IMG_Y0: begin
            row_offset_next = {8'd0, data_byte};
            phase_next      = PH_IMG_Y1;
          end
          PH_IMG_Y1: begin
            row_offset_next    = {data_byte, row_offset[7:0]};
            pixel_pointer_next = cfg.frame_base + row_prod[ADDR_BITS-1:0];
            size_left_next     = size_dec2;
            phase_next         = (size_dec2 != '0) ? PH_IMG_X : PH_TYPE;
          end
          PH_IMG_X: begin
            pixel_pointer_next = pixel_pointer + ADDR_BITS'(data_byte);
            phase_next         = PH_IMG_N;
          end
          PH_IMG_N: begin
            size_left_next = size_dec2;
            run_left_next  = data_byte;
            if (data_byte != 8'd0)
              phase_next = PH_IMG_PIX;
            else
              phase_next = (size_dec2 != '0) ? PH_IMG_X : PH_TYPE;
          end
          PH_IMG_PIX: begin
            res_valid          = 1'b1;
            res.kind           = KIND_PIXEL;
            res.address        = pixel_pointer;
            res.value          = data_byte;
            pixel_pointer_next = pixel_pointer + 1'b1;
            size_left_next     = size_dec1;
            run_left_next      = run_dec;
            if (run_dec == 8'd0)
              phase_next = (size_dec1 != '0) ? PH_IMG_X : PH_TYPE;
          end
          default: phase_next = PH_TYPE;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TYPE;
      chunk_kind     <= '0;
      size_left      <= '0;
      size_cnt       <= '0;
      pal_lane       <= '0;
      pal_entry      <= '0;
      held_color     <= '0;
      row_offset     <= '0;
      pixel_pointer  <= '0;
      run_left       <= '0;
      sound_dropping <= 1'b0;
      ring_write_pos <= '0;
      ring_read_pos  <= '0;
      bytes_received <= '0;
      bytes_consumed <= '0;
    end else begin
      phase          <= phase_next;
      chunk_kind     <= chunk_kind_next;
      size_left      <= size_left_next;
      size_cnt       <= size_cnt_next;
      pal_lane       <= pal_lane_next;
      pal_entry      <= pal_entry_next;
      held_color     <= held_color_next;
      row_offset     <= row_offset_next;
      pixel_pointer  <= pixel_pointer_next;
      run_left       <= run_left_next;
      sound_dropping <= sound_dropping_next;
      ring_write_pos <= ring_write_pos_next;
      ring_read_pos  <= ring_read_pos_next;
      bytes_received <= bytes_received_next;
      bytes_consumed <= bytes_consumed_next;
    end
  end

endmodule

### rtl/mcsd_emitter.sv
// Result register: holds one descriptor and plays it out as one or four beats.
// Depends on mcsd_pkg.
module mcsd_emitter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  mcsd_pkg::res_t                 res_in,
  output logic                           can_take,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     kind,
  output logic [mcsd_pkg::ADDR_BITS-1:0] address,
  output logic [7:0]                     value,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  output logic                           last
);
  import mcsd_pkg::*;

  res_t       desc;
  logic       busy;
  logic [1:0] beat;

  assign last      = !desc.quad || (beat == 2'd3);
  assign out_valid = busy;
  // Free for a new descriptor when empty or its final beat goes this cycle
  assign can_take  = !busy || (out_ready && last);

  assign kind    = desc.kind;
  assign address = desc.address + ADDR_BITS'(beat);
  assign value   = desc.value;
  assign red     = desc.red;
  assign green   = desc.green;
  assign blue    = desc.blue;

  // Beat sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= '0;
    end else begin
      if (busy && out_ready) begin
        if (last) busy <= 1'b0;
        else      beat <= beat + 2'd1;
      end
      if (load) begin
        busy <= 1'b1;
        beat <= '0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) desc <= res_in;
  end

endmodule

### rtl/movie_chunk_stream_decoder_core.sv
// Top level of the movie chunk stream decoder.
// Depends on mcsd_pkg, mcsd_cfg_regs, mcsd_parser and mcsd_emitter.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat per stream byte
//   (action = 0) or per audio serve request (action = 1).
//   Output channel (out_valid/out_ready): result beats (kind, address,
//   value, red, green, blue), last marking the final result of an input beat.
//   Configuration: cfg_wen/cfg_index/cfg_data, written while idle.
// Results of an input beat appear in the cycle after it is accepted.
// Throughput: one input beat per cycle while each causes at most one result
//   and the receiver is ready; the palette trailer byte causes four results
//   and holds the result register until all are taken. The parse state
//   machine and result register update in the same cycle: no wider bound.
// A beat that causes no result still waits for the result register to free.
// Reset (synchronous, rst high): parser waits for a type byte, all counters
//   and ring pointers clear, configuration returns to its default values.
// Receiver stall: the pending result is held; in_ready drops until its last
//   beat is taken.
module movie_chunk_stream_decoder_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [mcsd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mcsd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               action,
  input  logic [7:0]                         data_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         kind,
  output logic [mcsd_pkg::ADDR_BITS-1:0]     address,
  output logic [7:0]                         value,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  output logic                               last
);
  import mcsd_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic accept;

  assign accept = in_valid && in_ready;

  mcsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (action),
    .data_byte (data_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  mcsd_emitter u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .res_in    (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .address   (address),
    .value     (value),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .last      (last)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for movie_chunk_stream_decoder_core: feeds chunked movie byte streams and audio
// serve requests and checks every result beat against a decoder model kept inside the bench.
// Depends on rtl/mcsd_pkg.sv and rtl/movie_chunk_stream_decoder_core.sv.
module tb;
  import mcsd_pkg::*;

  // Parse phases of the bench's own decoder model
  typedef enum logic [3:0] {
    P_TYPE, P_SIZE, P_SKIPSIZE, P_PAL, P_PALTAIL, P_SOUND,
    P_ROW_LO, P_ROW_HI, P_SKIP, P_RUN, P_PIX
  } parse_e;

  typedef struct {
    logic [2:0]           kind;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           val;
    logic [7:0]           r;
    logic [7:0]           g;
    logic [7:0]           b;
    logic                 last;
  } beat_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_wen;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic                     action;
  logic [7:0]               data_byte;
  logic                     out_valid;
  logic                     out_ready;
  logic [2:0]               kind;
  logic [ADDR_BITS-1:0]     address;
  logic [7:0]               value;
  logic [7:0]               red;
  logic [7:0]               green;
  logic [7:0]               blue;
  logic                     last;

  // Shadow configuration and decoder state
  cfg_t                 cfg;
  parse_e               ph;
  logic [1:0]           chunk;
  logic [31:0]          size_left;
  logic [9:0]           idx;
  logic [15:0]          held;
  logic [15:0]          row;
  logic [ADDR_BITS-1:0] ptr;
  logic [7:0]           run_left;
  logic                 drop;
  logic [15:0]          wr_pos;
  logic [15:0]          rd_pos;
  logic [31:0]          recv_cnt;
  logic [31:0]          used_cnt;

  beat_t pending_q[$];
  beat_t fresh_q[$];
  beat_t oldest;

  int fails = 0;
  int beats_in = 0;
  int beats_out = 0;
  int kind_seen[5] = '{default: 0};
  int cfg_phases = 0;
  int park_cycles = 0;
  bit src_lazy = 1'b0;
  bit sink_lazy = 1'b0;
  bit mix_serve = 1'b0;

  movie_chunk_stream_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .address   (address),
    .value     (value),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .last      (last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- decoder model

  function automatic void emit(input logic [2:0] k, input logic [ADDR_BITS-1:0] a,
                               input logic [7:0] v, input logic [7:0] cr,
                               input logic [7:0] cg, input logic [7:0] cb);
    beat_t item;
    item.kind = k;
    item.addr = a;
    item.val  = v;
    item.r    = cr;
    item.g    = cg;
    item.b    = cb;
    item.last = 1'b0;
    fresh_q.push_back(item);
  endfunction

  function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] d);
    return (a > d) ? a - d : 32'd0;
  endfunction

  // colour component scaled by the palette shift, high bits dropped
  function automatic logic [7:0] tone(input logic [7:0] c);
    logic [7:0] t;
    t = c << cfg.palette_shift;
    return t;
  endfunction

  function automatic logic [7:0] chunk_tag(input logic [1:0] k);
    return {6'd0, k} + 8'd1;
  endfunction

  // size complete: decide what the payload is
  function automatic void open_chunk();
    ph = P_TYPE;
    case (chunk)
      CHUNK_PALETTE: begin
        idx  = '0;
        held = '0;
        ph   = P_PAL;
      end
      CHUNK_SOUND: if (size_left != 0) begin
        drop = (recv_cnt - used_cnt) >= 32'(cfg.ring_size);
        ph   = P_SOUND;
      end
      CHUNK_IMAGE: if (size_left != 0) begin
        row = '0;
        ph  = P_ROW_LO;
      end
      default: emit(KIND_DONE, '0, 8'd0, 8'd0, 8'd0, 8'd0);
    endcase
  endfunction

  // Advance the model by one accepted beat and queue the results it causes
  function automatic void decode_beat(input logic act, input logic [7:0] b);
    logic [31:0] sum;
    logic [7:0]  t;
    logic [9:0]  lane;
    fresh_q.delete();
    if (act) begin
      emit(KIND_SERVED, ADDR_BITS'(rd_pos), 8'd0, 8'd0, 8'd0, 8'd0);
      sum = 32'(rd_pos) + 32'(cfg.serve_size);
      if (sum >= 32'(cfg.ring_size))
        sum = sum - 32'(cfg.ring_size);
      rd_pos   = sum[15:0];
      used_cnt = used_cnt + 32'(cfg.serve_size);
    end else begin
      case (ph)
        P_TYPE: begin
          t         = b - 8'd1;
          idx       = '0;
          size_left = '0;
          if (t > 8'd3) begin
            ph = P_SKIPSIZE;
          end else begin
            chunk = t[1:0];
            ph    = P_SIZE;
          end
        end
        P_SIZE, P_SKIPSIZE: begin
          size_left = size_left | (32'(b) << (8 * idx[1:0]));
          idx       = idx + 10'd1;
          if (idx >= 10'd4) begin
            idx = '0;
            if (ph == P_SIZE)
              open_chunk();
            else
              ph = P_TYPE;
          end
        end
        P_PAL: begin
          lane = idx % 10'd3;
          if (lane == 10'd0)
            held = {8'd0, b};
          else if (lane == 10'd1)
            held = {b, held[7:0]};
          else
            emit(KIND_PALETTE, ADDR_BITS'(idx / 10'd3), 8'd0,
                 tone(held[7:0]), tone(held[15:8]), tone(b));
          idx = idx + 10'd1;
          if (idx >= 10'(3 * PAL_ENTRIES))
            ph = P_PALTAIL;
        end
        P_PALTAIL: begin
          for (int i = 0; i < 4; i++)
            emit(KIND_PIXEL, cfg.frame_base + ADDR_BITS'(i), cfg.overscan_color,
                 8'd0, 8'd0, 8'd0);
          idx = '0;
          ph  = P_TYPE;
        end
        P_SOUND: begin
          if (!drop) begin
            emit(KIND_AUDIO, ADDR_BITS'(wr_pos), b, 8'd0, 8'd0, 8'd0);
            wr_pos   = (32'(wr_pos) + 32'd1 >= 32'(cfg.ring_size)) ? 16'd0 : wr_pos + 16'd1;
            recv_cnt = recv_cnt + 32'd1;
          end
          size_left = size_left - 32'd1;
          if (size_left == 0)
            ph = P_TYPE;
        end
        P_ROW_LO: begin
          row = {8'd0, b};
          ph  = P_ROW_HI;
        end
        P_ROW_HI: begin
          row       = {b, row[7:0]};
          ptr       = cfg.frame_base + ADDR_BITS'(32'(row) * 32'(cfg.row_stride));
          size_left = floor_sub(size_left, 32'd2);
          ph        = (size_left != 0) ? P_SKIP : P_TYPE;
        end
        P_SKIP: begin
          ptr = ptr + ADDR_BITS'(b);
          ph  = P_RUN;
        end
        P_RUN: begin
          size_left = floor_sub(size_left, 32'd2);
          run_left  = b;
          if (b != 0)
            ph = P_PIX;
          else
            ph = (size_left != 0) ? P_SKIP : P_TYPE;
        end
        P_PIX: begin
          emit(KIND_PIXEL, ptr, b, 8'd0, 8'd0, 8'd0);
          ptr       = ptr + 1'b1;
          size_left = floor_sub(size_left, 32'd1);
          run_left  = run_left - 8'd1;
          if (run_left == 0)
            ph = (size_left != 0) ? P_SKIP : P_TYPE;
        end
        default: ph = P_TYPE;
      endcase
    end
    if (fresh_q.size() > 0)
      fresh_q[fresh_q.size() - 1].last = 1'b1;
    foreach (fresh_q[i])
      pending_q.push_back(fresh_q[i]);
  endfunction

  // ---------------------------------------------------------------- drivers

  // One input beat: optional gap, then hold valid until accepted
  task automatic send_beat(input logic act, input logic [7:0] b);
    int gap;
    gap = src_lazy ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_beat(act, b);
    beats_in++;
  endtask

  // Stream byte, now and then preceded by a serve once enough audio is buffered
  task automatic stream_byte(input logic [7:0] b);
    logic [31:0] fill;
    fill = recv_cnt - used_cnt;
    if (mix_serve && !fill[31] && fill >= 32'(cfg.serve_size) && $urandom_range(0, 7) == 0)
      send_beat(1'b1, 8'($urandom));
    send_beat(1'b0, b);
  endtask

  task automatic send_header(input logic [7:0] code_byte, input logic [31:0] len);
    stream_byte(code_byte);
    for (int i = 0; i < 4; i++)
      stream_byte(len[8*i +: 8]);
  endtask

  // Random bytes until the parser is back at a chunk boundary
  task automatic finish_chunk();
    while (ph != P_TYPE)
      stream_byte(8'($urandom));
  endtask

  // Image chunk with short runs so that the size drives the pair loop
  task automatic image_chunk(input logic [31:0] len);
    send_header(chunk_tag(CHUNK_IMAGE), len);
    while (ph != P_TYPE)
      stream_byte((ph == P_RUN) ? 8'($urandom_range(0, 4)) : 8'($urandom));
  endtask

  task automatic palette_chunk();
    logic [7:0] c;
    send_header(chunk_tag(CHUNK_PALETTE), $urandom);
    for (int e = 0; e < PAL_ENTRIES; e++)
      for (int l = 0; l < 3; l++) begin
        c = (e == 0) ? 8'h00 : (e == 1) ? 8'hFF : 8'($urandom);
        stream_byte(c);
      end
    stream_byte(8'($urandom));  // trailer, answered by the overscan writes
  endtask

  // Drop valid, wait for every expected beat, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] which,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    case (which)
      CFG_FRAME_BASE:     cfg.frame_base     = val[ADDR_BITS-1:0];
      CFG_ROW_STRIDE:     cfg.row_stride     = val[15:0];
      CFG_RING_SIZE:      cfg.ring_size      = val[15:0];
      CFG_SERVE_SIZE:     cfg.serve_size     = val[15:0];
      CFG_OVERSCAN_COLOR: cfg.overscan_color = val[7:0];
      CFG_PALETTE_SHIFT:  cfg.palette_shift  = val[1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [23:0] base, input logic [15:0] stride,
                           input logic [15:0] ring, input logic [15:0] serve,
                           input logic [7:0] ovs, input logic [1:0] sh);
    settle();
    write_reg(CFG_FRAME_BASE, base);
    write_reg(CFG_ROW_STRIDE, 24'(stride));
    write_reg(CFG_RING_SIZE, 24'(ring));
    write_reg(CFG_SERVE_SIZE, 24'(serve));
    write_reg(CFG_OVERSCAN_COLOR, 24'(ovs));
    write_reg(CFG_PALETTE_SHIFT, 24'(sh));
    cfg_phases++;
  endtask

  // ---------------------------------------------------------------- receiver and checker

  // Per-beat random stall, plus a long park on request
  initial begin : sink
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = sink_lazy ? $urandom_range(0, 14) : 0;
      if (park_cycles > 0) begin
        stall       = park_cycles;
        park_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (kind <= KIND_DONE)
        kind_seen[kind]++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: kind %0d address 0x%0h", kind, address);
        fails++;
      end else begin
        oldest = pending_q.pop_front();
        check_field("kind", 32'(oldest.kind), 32'(kind));
        check_field("address", 32'(oldest.addr), 32'(address));
        check_field("value", 32'(oldest.val), 32'(value));
        check_field("red", 32'(oldest.r), 32'(red));
        check_field("green", 32'(oldest.g), 32'(green));
        check_field("blue", 32'(oldest.b), 32'(blue));
        check_field("last", 32'(oldest.last), 32'(last));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Done chunks (with and without payload), unknown types, empty chunks
  task automatic test_chunk_headers();
    send_header(chunk_tag(CHUNK_DONE), 32'd0);
    // done payload is not skipped: the next bytes parse as fresh chunks
    send_header(chunk_tag(CHUNK_DONE), 32'd5);
    send_header(8'h00, 32'hFFFF_FFFF);
    send_header(8'hFF, 32'h0000_0000);
    send_header(8'h05, 32'h1234_5678);
    send_header(chunk_tag(CHUNK_SOUND), 32'd0);
    send_header(chunk_tag(CHUNK_IMAGE), 32'd0);
  endtask

  // Tiny ring: write wrap, serve wrap, serve mid-chunk, full ring drop
  task automatic test_sound_ring();
    settle();
    write_reg(CFG_RING_SIZE, 24'd4);
    write_reg(CFG_SERVE_SIZE, 24'd3);
    send_header(chunk_tag(CHUNK_SOUND), 32'd6);
    stream_byte(8'h00);
    stream_byte(8'hFF);
    stream_byte(8'hA5);
    stream_byte(8'h5A);
    send_beat(1'b1, 8'hFF);
    stream_byte(8'h3C);
    stream_byte(8'hC3);
    send_header(chunk_tag(CHUNK_SOUND), 32'd3);
    finish_chunk();
    send_header(chunk_tag(CHUNK_SOUND), 32'd2);  // ring full: dropped
    finish_chunk();
    send_beat(1'b1, 8'h00);
    send_beat(1'b1, 8'h55);
    send_header(chunk_tag(CHUNK_SOUND), 32'd1);
    stream_byte(8'h81);
  endtask

  // Saturating size, run read past the size, zero-length run, address wrap
  task automatic test_image_runs();
    settle();
    write_reg(CFG_FRAME_BASE, 24'hFFFF00);
    send_header(chunk_tag(CHUNK_IMAGE), 32'd1);
    stream_byte(8'hFF);
    stream_byte(8'hFF);
    send_header(chunk_tag(CHUNK_IMAGE), 32'd3);
    stream_byte(8'h01);
    stream_byte(8'h00);
    stream_byte(8'hFF);
    stream_byte(8'h02);
    stream_byte(8'h00);
    stream_byte(8'hFF);
    send_header(chunk_tag(CHUNK_IMAGE), 32'd8);
    stream_byte(8'h00);
    stream_byte(8'h00);
    stream_byte(8'h00);
    stream_byte(8'h00);
    stream_byte(8'h10);
    stream_byte(8'h03);
    stream_byte(8'h11);
    stream_byte(8'h22);
    stream_byte(8'h33);
  endtask

  // One palette per shift; overscan writes wrap past the top of memory
  task automatic test_palette();
    settle();
    write_reg(CFG_FRAME_BASE, 24'hFFFFFE);
    write_reg(CFG_OVERSCAN_COLOR, 24'hFF);
    sink_lazy = 1'b1;
    palette_chunk();
    settle();
    write_reg(CFG_PALETTE_SHIFT, 24'd0);
    write_reg(CFG_OVERSCAN_COLOR, 24'h5A);
    src_lazy = 1'b1;
    palette_chunk();
    settle();
    write_reg(CFG_PALETTE_SHIFT, 24'd1);
    write_reg(CFG_FRAME_BASE, 24'd0);
    src_lazy = 1'b0;
    palette_chunk();
  endtask

  // Receiver parks while the sender keeps offering audio at full rate
  task automatic test_backpressure();
    settle();
    write_reg(CFG_RING_SIZE, 24'd1000);
    write_reg(CFG_SERVE_SIZE, 24'd10);
    src_lazy    = 1'b0;
    sink_lazy   = 1'b0;
    mix_serve   = 1'b1;
    park_cycles = 300;
    send_header(chunk_tag(CHUNK_SOUND), 32'd60);
    finish_chunk();
  endtask

  task automatic random_chunk();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: begin
        send_header(chunk_tag(CHUNK_SOUND), $urandom_range(0, 10));
        finish_chunk();
      end
      4, 5, 6: image_chunk($urandom_range(0, 16));
      7: send_header(chunk_tag(CHUNK_DONE), $urandom_range(0, 3));
      8: send_header(8'($urandom_range(5, 256)), $urandom);  // unknown type, 256 gives 0
      default: begin
        // image with unshaped content, runs up to 255
        send_header(chunk_tag(CHUNK_IMAGE), $urandom_range(1, 12));
        finish_chunk();
      end
    endcase
  endtask

  // Random chunk mix under four settings, extremes last
  task automatic test_random();
    int stop;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: apply_cfg(24'($urandom), 16'($urandom_range(1, 65535)),
                     16'($urandom_range(16, 64)), 16'($urandom_range(1, 8)),
                     8'($urandom), 2'($urandom_range(0, 2)));
        1: apply_cfg(24'd0, 16'd1, 16'd65535, 16'd1, 8'd0, 2'd0);
        2: apply_cfg(24'($urandom), 16'($urandom_range(1, 65535)),
                     16'($urandom_range(1, 8)), 16'($urandom_range(1, 3)),
                     8'($urandom), 2'($urandom_range(0, 2)));
        default: apply_cfg(24'hFFFFFF, 16'd65535, 16'd1, 16'd65535, 8'hFF, 2'd2);
      endcase
      src_lazy  = (p != 1);
      sink_lazy = (p == 0 || p == 3);
      if (p == 3) begin
        // read position runs far past the ring end; taking off one ring size does not fold it back
        send_beat(1'b1, 8'h00);
        send_beat(1'b1, 8'hFF);
      end
      stop = beats_in + 40;
      while (beats_in < stop)
        random_chunk();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    action    = 1'b0;
    data_byte = 8'd0;
    cfg.frame_base     = '0;
    cfg.row_stride     = ROW_STRIDE_RST;
    cfg.ring_size      = RING_SIZE_RST;
    cfg.serve_size     = SERVE_SIZE_RST;
    cfg.overscan_color = '0;
    cfg.palette_shift  = PAL_SHIFT_RST;
    ph        = P_TYPE;
    chunk     = '0;
    size_left = '0;
    idx       = '0;
    held      = '0;
    row       = '0;
    ptr       = '0;
    run_left  = '0;
    drop      = 1'b0;
    wr_pos    = '0;
    rd_pos    = '0;
    recv_cnt  = '0;
    used_cnt  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_chunk_headers();
    test_sound_ring();
    test_image_runs();
    test_palette();
    test_backpressure();
    test_random();
    settle();
    repeat (16) @(negedge clk);

    $display("Covered %0d input beats, %0d result beats over %0d register settings",
             beats_in, beats_out, cfg_phases);
    $display("Result mix: %0d pixel, %0d palette, %0d audio, %0d serve, %0d frame-done",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
